// ----- rtl/core/fsdf_pkg.sv -----
// Package for the four-digit segment display formatter.
// Holds the driver-chip byte codes, the glyph table, the character map and the FSM type.
// No dependencies.
package fsdf_pkg;

  localparam int BIN_W   = 14;
  localparam int BCD_W   = 16;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 4;
  localparam int GLYPH_W = 5;
  localparam int NDIG    = 4;

  localparam logic [14:0] VAL_MAX  = 15'd19999;
  localparam logic [14:0] VAL_WRAP = 15'd10000;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hc0;
  localparam logic [7:0] CMD_DISP  = 8'h88;
  localparam logic [7:0] POINT_BIT = 8'h20;

  localparam logic [IDX_W-1:0] IDX_DATA  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_ADDR  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_SEG0  = 4'd2;
  localparam logic [IDX_W-1:0] IDX_SEGL  = 4'd9;
  localparam logic [IDX_W-1:0] IDX_LAST  = 4'd10;

  localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 5'd16;
  localparam logic [GLYPH_W-1:0] GLYPH_R     = 5'd17;
  localparam logic [GLYPH_W-1:0] GLYPH_N     = 5'd18;
  localparam logic [GLYPH_W-1:0] GLYPH_DASH  = 5'd19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                hit;
    logic [GLYPH_W-1:0]  code;
  } char_map_t;

  function automatic logic [15:0] seg_lookup(input logic [GLYPH_W-1:0] g);
    logic [15:0] s;
    case (g)
      5'd0:    s = 16'h1f08;
      5'd1:    s = 16'h0600;
      5'd2:    s = 16'h1b10;
      5'd3:    s = 16'h0f10;
      5'd4:    s = 16'h0618;
      5'd5:    s = 16'h0d18;
      5'd6:    s = 16'h1d18;
      5'd7:    s = 16'h0700;
      5'd8:    s = 16'h1f18;
      5'd9:    s = 16'h0f18;
      5'd10:   s = 16'h1718;
      5'd11:   s = 16'h1c18;
      5'd12:   s = 16'h1908;
      5'd13:   s = 16'h1e10;
      5'd14:   s = 16'h1918;
      5'd15:   s = 16'h1118;
      5'd17:   s = 16'h1010;
      5'd18:   s = 16'h1410;
      5'd19:   s = 16'h0010;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  function automatic char_map_t map_char(input logic [7:0] c);
    char_map_t m;
    logic [7:0] d;
    m.hit  = 1'b1;
    m.code = GLYPH_BLANK;
    d      = 8'd0;
    if (c inside {["0":"9"]}) begin
      d      = c - 8'h30;
      m.code = d[GLYPH_W-1:0];
    end else if (c inside {["a":"f"]}) begin
      d      = c - 8'h57;
      m.code = d[GLYPH_W-1:0];
    end else if (c inside {["A":"F"]}) begin
      d      = c - 8'h37;
      m.code = d[GLYPH_W-1:0];
    end else if (c == " ") begin
      m.code = GLYPH_BLANK;
    end else if (c == "r") begin
      m.code = GLYPH_R;
    end else if (c == "n") begin
      m.code = GLYPH_N;
    end else if (c == "-") begin
      m.code = GLYPH_DASH;
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/four_digit_segment_display_formatter.sv -----
// Top level of the four-digit segment display formatter.
// Depends on fsdf_pkg and fsdf_bcd.
//
// Each input transaction produces eleven output transactions: the data
// command, the address command followed by two segment bytes per digit from
// left to right, and the display control command. A number-mode update waits
// longer than a text-mode update before its first byte can enter the output
// register: it first runs the conversion, one bit per cycle through the
// shift-and-add-three converter, and then loads the glyphs; after that the
// bytes leave at one per cycle while out_stall is low. A new input transaction
// is taken once the last byte has entered the output register.
module four_digit_segment_display_formatter import fsdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [14:0] in_number_value,
  input  logic [2:0]  in_point_position,
  input  logic [7:0]  in_text_char_0,
  input  logic [7:0]  in_text_char_1,
  input  logic [7:0]  in_text_char_2,
  input  logic [7:0]  in_text_char_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_strobe_release,
  output logic        out_last
);

  state_t state_r, state_nxt;

  logic [GLYPH_W-1:0] glyph_r [NDIG];
  logic [GLYPH_W-1:0] glyph_nxt [NDIG];
  logic [2:0]         point_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               out_free;
  logic               bcd_start;
  logic               bcd_done;
  logic [BCD_W-1:0]   bcd;
  logic [14:0]        val_sat;
  logic [14:0]        val_red;
  logic               emit_en;
  logic               load_text;
  logic               load_num;

  logic [7:0]         text_char [NDIG];
  char_map_t          cmap [NDIG];
  logic [GLYPH_W-1:0] num_glyph [NDIG];

  logic [IDX_W-1:0]   seg_off;
  logic [1:0]         dig_sel;
  logic [15:0]        seg_pair;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign val_sat = (in_number_value > VAL_MAX) ? VAL_MAX : in_number_value;
  assign val_red = (val_sat >= VAL_WRAP) ? val_sat - VAL_WRAP : val_sat;

  fsdf_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (val_red[BIN_W-1:0]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  assign text_char[0] = in_text_char_0;
  assign text_char[1] = in_text_char_1;
  assign text_char[2] = in_text_char_2;
  assign text_char[3] = in_text_char_3;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      cmap[i] = map_char(text_char[i]);
    end
  end

  // Leading zeros are blanked from the left until a nonzero digit or the point digit.
  always_comb begin
    logic stop;
    stop = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      num_glyph[i] = {1'b0, bcd[BCD_W-1-4*i -: 4]};
    end
    for (int i = 0; i < NDIG - 1; i++) begin
      if (num_glyph[i] != '0 || point_r == 3'(i + 1)) begin
        stop = 1'b1;
      end
      if (!stop) begin
        num_glyph[i] = GLYPH_BLANK;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_command ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && idx_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    bcd_start = 1'b0;
    load_text = 1'b0;
    load_num  = 1'b0;
    emit_en   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        bcd_start = in_valid && !in_command;
        load_text = in_valid && in_command;
      end
      ST_CONV: begin
        load_num = bcd_done;
      end
      ST_EMIT: begin
        emit_en = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      glyph_nxt[i] = glyph_r[i];
      if (load_text && cmap[i].hit) begin
        glyph_nxt[i] = cmap[i].code;
      end
      if (load_num) begin
        glyph_nxt[i] = num_glyph[i];
      end
    end
  end

  assign seg_off  = idx_r - IDX_SEG0;
  assign dig_sel  = seg_off[2:1];
  assign seg_pair = seg_lookup(glyph_r[dig_sel]);

  always_comb begin
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_strobe_nxt = out_strobe_r;
    out_last_nxt   = out_last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      idx_nxt = IDX_DATA;
    end
    if (emit_en) begin
      out_valid_nxt  = 1'b1;
      out_strobe_nxt = 1'b0;
      out_last_nxt   = 1'b0;
      idx_nxt        = idx_r + 1'b1;
      case (idx_r)
        IDX_DATA: begin
          out_byte_nxt   = CMD_DATA;
          out_strobe_nxt = 1'b1;
        end
        IDX_ADDR: begin
          out_byte_nxt = CMD_ADDR;
        end
        IDX_LAST: begin
          out_byte_nxt   = CMD_DISP;
          out_strobe_nxt = 1'b1;
          out_last_nxt   = 1'b1;
        end
        default: begin
          if (!seg_off[0]) begin
            out_byte_nxt = seg_pair[15:8];
          end else begin
            out_byte_nxt = seg_pair[7:0];
            if (point_r == {1'b0, dig_sel} + 3'd1) begin
              out_byte_nxt = seg_pair[7:0] | POINT_BIT;
            end
          end
          out_strobe_nxt = (idx_r == IDX_SEGL);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= IDX_DATA;
      out_valid_r <= 1'b0;
      glyph_r[0]  <= 5'd1;
      glyph_r[1]  <= 5'd2;
      glyph_r[2]  <= 5'd3;
      glyph_r[3]  <= 5'd4;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NDIG; i++) begin
        glyph_r[i] <= glyph_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      point_r <= in_point_position;
    end
    out_byte_r   <= out_byte_nxt;
    out_strobe_r <= out_strobe_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_strobe_release = out_strobe_r;
  assign out_last           = out_last_r;

endmodule

// ----- rtl/core/fsdf_bcd.sv -----
// Bit-serial binary to BCD converter using the shift-and-add-three method.
// Converts a 14-bit value into four decimal digits, one bit per cycle.
// Depends on fsdf_pkg.
module fsdf_bcd import fsdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BIN_W-1:0] bin,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic [BIN_W-1:0] shift_r, shift_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = bin;
      bcd_nxt   = '0;
      cnt_nxt   = CNT_W'(BIN_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[BIN_W-2:0], 1'b0};
      bcd_nxt   = {adj[BCD_W-2:0], shift_r[BIN_W-1]};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ----- verif/fsdf_checker.sv -----
// Checker for the four-digit segment display formatter: watches both channels,
// predicts the eleven driver-chip bytes of every update and compares them.
// Standalone; instantiated beside the block by tb_top.
module fsdf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [14:0] in_number_value,
  input  logic [2:0]  in_point_position,
  input  logic [7:0]  in_text_char_0,
  input  logic [7:0]  in_text_char_1,
  input  logic [7:0]  in_text_char_2,
  input  logic [7:0]  in_text_char_3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_strobe_release,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [7:0] code;
    logic       strobe;
    logic       last;
  } drv_byte_t;

  localparam logic [7:0] DRV_DATA    = 8'h40;
  localparam logic [7:0] DRV_ADDR    = 8'hc0;
  localparam logic [7:0] DRV_DISPLAY = 8'h88;
  localparam logic [7:0] DRV_POINT   = 8'h20;

  localparam logic [4:0] GL_BLANK = 5'd16;
  localparam logic [4:0] GL_R     = 5'd17;
  localparam logic [4:0] GL_N     = 5'd18;
  localparam logic [4:0] GL_DASH  = 5'd19;

  // Segment pair per glyph, glyph 0 in the lowest slot.
  localparam logic [19:0][15:0] SEG_ROM = {
    16'h0010, 16'h1410, 16'h1010, 16'h0000,
    16'h1118, 16'h1918, 16'h1e10, 16'h1908,
    16'h1c18, 16'h1718, 16'h0f18, 16'h1f18,
    16'h0700, 16'h1d18, 16'h0d18, 16'h0618,
    16'h0f10, 16'h1b10, 16'h0600, 16'h1f08
  };

  drv_byte_t  bytes_due[$];
  drv_byte_t  want;
  logic [4:0] shown_glyph [4];
  int         n_err;
  int         n_checked;

  // Bit 5 set when the character has a glyph.
  function automatic logic [5:0] decode_char(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[4:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[4:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[4:0]};
    end
    if (c == " ") return {1'b1, GL_BLANK};
    if (c == "r") return {1'b1, GL_R};
    if (c == "n") return {1'b1, GL_N};
    if (c == "-") return {1'b1, GL_DASH};
    return 6'd0;
  endfunction

  task automatic render_update(input logic cmd, input logic [14:0] value,
                               input logic [2:0] pt, input logic [31:0] chars);
    int         v;
    logic       leading;
    logic [5:0] m;
    logic [15:0] seg;
    logic [7:0] lo;
    if (!cmd) begin
      v = value;
      if (v > 19999) v = 19999;
      if (v >= 10000) v = v - 10000;
      shown_glyph[0] = 5'(v / 1000);
      shown_glyph[1] = 5'((v % 1000) / 100);
      shown_glyph[2] = 5'((v % 100) / 10);
      shown_glyph[3] = 5'(v % 10);
      leading = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (shown_glyph[i] != 5'd0 || pt == i + 1) leading = 1'b0;
        if (leading) shown_glyph[i] = GL_BLANK;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        m = decode_char(chars[31 - 8 * i -: 8]);
        if (m[5]) shown_glyph[i] = m[4:0];
      end
    end
    bytes_due.push_back({DRV_DATA, 1'b1, 1'b0});
    bytes_due.push_back({DRV_ADDR, 1'b0, 1'b0});
    for (int i = 0; i < 4; i++) begin
      seg = SEG_ROM[shown_glyph[i]];
      lo  = seg[7:0];
      if (pt == i + 1) lo = lo | DRV_POINT;
      bytes_due.push_back({seg[15:8], 1'b0, 1'b0});
      bytes_due.push_back({lo, i == 3, 1'b0});
    end
    bytes_due.push_back({DRV_DISPLAY, 1'b1, 1'b1});
  endtask

  initial begin
    n_err     = 0;
    n_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      shown_glyph[0] = 5'd1;
      shown_glyph[1] = 5'd2;
      shown_glyph[2] = 5'd3;
      shown_glyph[3] = 5'd4;
      bytes_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected out transaction: out_byte %02h", out_byte);
          n_err++;
        end else begin
          want = bytes_due.pop_front();
          n_checked++;
          if (out_byte !== want.code) begin
            $error("out_byte: expected %02h, got %02h", want.code, out_byte);
            n_err++;
          end
          if (out_strobe_release !== want.strobe) begin
            $error("out_strobe_release: expected %0b, got %0b", want.strobe,
                   out_strobe_release);
            n_err++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            n_err++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        render_update(in_command, in_number_value, in_point_position,
                      {in_text_char_0, in_text_char_1, in_text_char_2, in_text_char_3});
      end
    end
    errors  <= n_err;
    pending <= bytes_due.size();
    checked <= n_checked;
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the testbench for the four-digit segment display formatter.
// Drives number and text updates with random gaps and stalls, instantiates
// the block with fsdf_checker beside it and gives the verdict.
module tb_top;

  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 350;
  localparam int HOLD_LEN  = 400;
  localparam logic CMD_NUMBER = 1'b0;
  localparam logic CMD_TEXT   = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [14:0] in_number_value;
  logic [2:0]  in_point_position;
  logic [7:0]  in_text_char_0;
  logic [7:0]  in_text_char_1;
  logic [7:0]  in_text_char_2;
  logic [7:0]  in_text_char_3;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_strobe_release;
  logic        out_last;

  int   errors;
  int   pending;
  int   checked;
  int   cycle_count = 0;
  int   n_number = 0;
  int   n_text = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  string charset = " 0123456789abcdefABCDEFrn-";

  always #10 clk = ~clk;

  four_digit_segment_display_formatter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_number_value    (in_number_value),
    .in_point_position  (in_point_position),
    .in_text_char_0     (in_text_char_0),
    .in_text_char_1     (in_text_char_1),
    .in_text_char_2     (in_text_char_2),
    .in_text_char_3     (in_text_char_3),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_strobe_release (out_strobe_release),
    .out_last           (out_last)
  );

  fsdf_checker monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_number_value    (in_number_value),
    .in_point_position  (in_point_position),
    .in_text_char_0     (in_text_char_0),
    .in_text_char_1     (in_text_char_1),
    .in_text_char_2     (in_text_char_2),
    .in_text_char_3     (in_text_char_3),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_strobe_release (out_strobe_release),
    .out_last           (out_last),
    .errors             (errors),
    .pending            (pending),
    .checked            (checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request so that the block
  // fills up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int k = 0; k < HOLD_LEN; k++) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  task automatic offer(input logic cmd, input logic [14:0] value,
                       input logic [2:0] pt, input logic [31:0] chars);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_number_value   <= value;
    in_point_position <= pt;
    in_text_char_0    <= chars[31:24];
    in_text_char_1    <= chars[23:16];
    in_text_char_2    <= chars[15:8];
    in_text_char_3    <= chars[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_TEXT) n_text++;
    else n_number++;
  endtask

  function automatic logic [14:0] random_value();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 15'($urandom_range(99));
    if (r < 55) return 15'($urandom_range(9999));
    if (r < 75) return 15'($urandom_range(19999, 10000));
    if (r < 88) return 15'($urandom_range(32767, 19999));
    return 15'($urandom);
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(99) < 70) return charset[$urandom_range(charset.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [2:0] random_point();
    if ($urandom_range(99) < 80) return 3'($urandom_range(4));
    return 3'($urandom_range(7));
  endfunction

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_NUMBER;
    in_number_value   = 15'd0;
    in_point_position = 3'd0;
    in_text_char_0    = 8'd0;
    in_text_char_1    = 8'd0;
    in_text_char_2    = 8'd0;
    in_text_char_3    = 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unmapped characters straight after reset show the reset glyphs.
    offer(CMD_TEXT, 15'd0, 3'd0, "xyz!");
    offer(CMD_NUMBER, 15'd0, 3'd0, 32'h0);
    offer(CMD_NUMBER, 15'd0, 3'd1, 32'h0);
    offer(CMD_NUMBER, 15'd0, 3'd2, 32'hffffffff);
    offer(CMD_NUMBER, 15'd5, 3'd4, 32'h0);
    offer(CMD_NUMBER, 15'd9999, 3'd3, 32'h0);
    offer(CMD_NUMBER, 15'd10000, 3'd0, 32'h0);
    offer(CMD_NUMBER, 15'd19999, 3'd1, 32'h0);
    offer(CMD_NUMBER, 15'd20000, 3'd2, 32'h0);
    offer(CMD_NUMBER, 15'd32767, 3'd7, 32'h0);
    offer(CMD_NUMBER, 15'd120, 3'd5, 32'h0);
    offer(CMD_NUMBER, 15'd7, 3'd6, 32'h0);
    offer(CMD_NUMBER, 15'd1005, 3'd2, 32'h0);
    offer(CMD_TEXT, 15'd0, 3'd1, "0123");
    offer(CMD_TEXT, 15'h7fff, 3'd2, "4567");
    offer(CMD_TEXT, 15'd0, 3'd3, "89ab");
    offer(CMD_TEXT, 15'd0, 3'd4, "cdef");
    offer(CMD_TEXT, 15'd0, 3'd0, "ABCD");
    offer(CMD_TEXT, 15'd0, 3'd7, "EF r");
    offer(CMD_TEXT, 15'd0, 3'd0, "n-  ");
    offer(CMD_TEXT, 15'd0, 3'd5, "G/:@");
    offer(CMD_TEXT, 15'd0, 3'd6, 32'hff80007f);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 80) hold_req = 1'b1;
      calm = (n >= 200 && n < 260);
      offer(1'($urandom_range(1)), random_value(), random_point(),
            {random_char(), random_char(), random_char(), random_char()});
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("tb_top: %0d number and %0d text updates sent, %0d bytes compared",
             n_number, n_text, checked);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
